@@ rtl/mwa_pkg.sv @@
// Shared sizes and constants for the multichannel window average block.
package mwa_pkg;

   // Block configuration.
   localparam int CHANNELS    = 12;
   localparam int WINDOW      = 12;
   localparam int SAMPLE_BITS = 16;

   // Fixed field widths of the request and response beats.
   localparam int CHAN_W   = 4;
   localparam int SAMPLE_W = 16;
   localparam int MEAN_W   = 16;

   // Derived storage sizes.
   localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_BITS   = $clog2(WINDOW);
   localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
   localparam int DEPTH       = CHANNELS * WINDOW;
   localparam int ADDR_BITS   = $clog2(DEPTH);

   // Reciprocal of WINDOW, rounded up, so that (sum * RECIP) >> RECIP_SHIFT
   // is the exact truncated quotient for every SUM_BITS-bit sum.
   localparam int RECIP_SHIFT = SUM_BITS + SLOT_BITS;
   localparam int RECIP_BITS  = SUM_BITS + 1;
   localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(
      ((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

endpackage

@@ rtl/multichannel_window_average_top.sv @@
// Top level of the multichannel moving average over a window of samples.
//
// Each request beat carries a channel index and a sample. The sample replaces
// the oldest one in that channel's window and the block returns one response
// beat with the truncated mean of the window; windows start at zero. A channel
// index of CHANNELS or more leaves all state alone and returns mean zero with
// bad_channel set. The block takes one beat per cycle while the response side
// keeps up, with no stall between beats of the same channel. The sample memory
// is read at the accepting edge into stage 1, the running sum is updated as the
// beat moves into stage 2 and the reciprocal multiply that divides by the window
// length fills the output register as the beat leaves stage 2.
// No clearing pass is needed after reset.
module multichannel_window_average_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mwa_pkg::CHAN_W-1:0]   req_channel,
   input  logic [mwa_pkg::SAMPLE_W-1:0] req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mwa_pkg::CHAN_W-1:0]   rsp_channel_out,
   output logic [mwa_pkg::MEAN_W-1:0]   rsp_mean,
   output logic                        rsp_bad_channel
);

   // Sample memory, one row of WINDOW slots per channel.
   logic [mwa_pkg::SAMPLE_BITS-1:0] window_mem [mwa_pkg::DEPTH];

   // Per-channel control state: next slot to replace, window-filled flag and running sum.
   logic [mwa_pkg::SLOT_BITS-1:0] slot_ff [mwa_pkg::CHANNELS];
   logic                          full_ff [mwa_pkg::CHANNELS];
   logic [mwa_pkg::SUM_BITS-1:0]  sum_ff  [mwa_pkg::CHANNELS];

   // Handshake between stages.
   logic accept;
   logic adv_s2;
   logic adv_out;

   // Request decode.
   logic                            req_bad;
   logic [mwa_pkg::CH_IDX_BITS-1:0] req_idx;
   logic [mwa_pkg::SAMPLE_BITS-1:0] req_val;
   logic [mwa_pkg::SLOT_BITS-1:0]   cur_slot;
   logic                            cur_full;
   logic [mwa_pkg::SLOT_BITS-1:0]   slot_in;
   logic [mwa_pkg::ADDR_BITS-1:0]   mem_addr;

   // Stage 1: memory read in flight.
   logic                            s1_valid_ff;
   logic [mwa_pkg::CHAN_W-1:0]      s1_channel_ff;
   logic                            s1_bad_ff;
   logic [mwa_pkg::CH_IDX_BITS-1:0] s1_idx_ff;
   logic [mwa_pkg::SAMPLE_BITS-1:0] s1_sample_ff;
   logic                            s1_full_ff;
   logic [mwa_pkg::SAMPLE_BITS-1:0] s1_old_ff;
   logic [mwa_pkg::SAMPLE_BITS-1:0] dropped;
   logic [mwa_pkg::SUM_BITS-1:0]    sum_cur;
   logic [mwa_pkg::SUM_BITS-1:0]    sum_in;

   // Stage 2: updated sum waiting for the divide.
   logic                         s2_valid_ff;
   logic [mwa_pkg::CHAN_W-1:0]   s2_channel_ff;
   logic                         s2_bad_ff;
   logic [mwa_pkg::SUM_BITS-1:0] s2_sum_ff;
   logic [mwa_pkg::PROD_BITS-1:0] product;
   logic [mwa_pkg::MEAN_W-1:0]   mean_in;

   // Output register.
   logic                       rsp_valid_ff;
   logic [mwa_pkg::CHAN_W-1:0] rsp_channel_ff;
   logic [mwa_pkg::MEAN_W-1:0] rsp_mean_ff;
   logic                       rsp_bad_ff;

   // Each stage moves when the one after it is empty or moving.
   assign adv_out   = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign adv_s2    = s1_valid_ff && (!s2_valid_ff || adv_out);
   assign req_ready = !s1_valid_ff || adv_s2;
   assign accept    = req_valid && req_ready;

   // Decode the request and find the slot it replaces.
   always_comb begin
      req_bad  = ({1'b0, req_channel} >= (mwa_pkg::CHAN_W + 1)'(mwa_pkg::CHANNELS));
      req_idx  = req_channel[mwa_pkg::CH_IDX_BITS-1:0];
      req_val  = mwa_pkg::SAMPLE_BITS'(req_sample);
      cur_slot = req_bad ? '0 : slot_ff[req_idx];
      cur_full = req_bad ? 1'b0 : full_ff[req_idx];
      if (cur_slot == mwa_pkg::SLOT_BITS'(mwa_pkg::WINDOW - 1)) begin
         slot_in = '0;
      end else begin
         slot_in = cur_slot + 1'b1;
      end
      mem_addr = mwa_pkg::ADDR_BITS'(mwa_pkg::ADDR_BITS'(req_idx)
                 * mwa_pkg::ADDR_BITS'(mwa_pkg::WINDOW))
                 + mwa_pkg::ADDR_BITS'(cur_slot);
   end

   // Slot pointer and fill flag advance on acceptance, so a following beat of
   // the same channel already sees the next slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mwa_pkg::CHANNELS; i++) begin
            slot_ff[i] <= '0;
            full_ff[i] <= 1'b0;
         end
      end else if (accept && !req_bad) begin
         slot_ff[req_idx] <= slot_in;
         if (slot_in == '0) begin
            full_ff[req_idx] <= 1'b1;
         end
      end
   end

   // Read the dropped sample and write the new one in the same cycle; the
   // read returns the old contents.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_old_ff <= window_mem[mem_addr];
         if (!req_bad) begin
            window_mem[mem_addr] <= req_val;
         end
      end
   end

   // Stage 1 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (adv_s2) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_channel_ff <= req_channel;
         s1_bad_ff     <= req_bad;
         s1_idx_ff     <= req_idx;
         s1_sample_ff  <= req_val;
         s1_full_ff    <= cur_full;
      end
   end

   // A slot not yet written since reset counts as zero.
   always_comb begin
      dropped = s1_full_ff ? s1_old_ff : '0;
      sum_cur = s1_bad_ff ? '0 : sum_ff[s1_idx_ff];
      sum_in  = sum_cur - mwa_pkg::SUM_BITS'(dropped)
                + mwa_pkg::SUM_BITS'(s1_sample_ff);
   end

   // Running sums are written as the beat leaves stage 1, before any later
   // beat can read them there.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mwa_pkg::CHANNELS; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (adv_s2 && !s1_bad_ff) begin
         sum_ff[s1_idx_ff] <= sum_in;
      end
   end

   // Stage 2 registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv_s2) begin
         s2_valid_ff <= 1'b1;
      end else if (adv_out) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_s2) begin
         s2_channel_ff <= s1_channel_ff;
         s2_bad_ff     <= s1_bad_ff;
         s2_sum_ff     <= sum_in;
      end
   end

   // Divide by the window length through the rounded-up reciprocal.
   always_comb begin
      product = mwa_pkg::PROD_BITS'(s2_sum_ff) * mwa_pkg::PROD_BITS'(mwa_pkg::RECIP);
      mean_in = s2_bad_ff ? '0 : mwa_pkg::MEAN_W'(product >> mwa_pkg::RECIP_SHIFT);
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         rsp_channel_ff <= s2_channel_ff;
         rsp_mean_ff    <= mean_in;
         rsp_bad_ff     <= s2_bad_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_mean        = rsp_mean_ff;
   assign rsp_bad_channel = rsp_bad_ff;

endmodule

@@ rtl/mwa_checker.sv @@
// Port-level checks for the multichannel window average block, with its bind.
module mwa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [mwa_pkg::CHAN_W-1:0]   req_channel,
   input logic [mwa_pkg::SAMPLE_W-1:0] req_sample,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [mwa_pkg::CHAN_W-1:0]   rsp_channel_out,
   input logic [mwa_pkg::MEAN_W-1:0]   rsp_mean,
   input logic                        rsp_bad_channel
);

   logic rsp_out_of_range;

   assign rsp_out_of_range =
      ({1'b0, rsp_channel_out} >= (mwa_pkg::CHAN_W + 1)'(mwa_pkg::CHANNELS));

   // A stalled request beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_channel)
         && $stable(req_sample))
      else $error("request beat changed while stalled");

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_out)
         && $stable(rsp_mean) && $stable(rsp_bad_channel))
      else $error("response beat changed while stalled");

   // The error flag matches the echoed channel being out of range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bad_channel == rsp_out_of_range))
      else $error("bad_channel does not match channel range");

   // A rejected channel reports a zero mean.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_channel |-> rsp_mean == '0)
      else $error("nonzero mean on a bad channel");

   // No response is valid right after a reset cycle.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind multichannel_window_average_top mwa_checker u_mwa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_channel     (req_channel),
   .req_sample      (req_sample),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_channel_out (rsp_channel_out),
   .rsp_mean        (rsp_mean),
   .rsp_bad_channel (rsp_bad_channel)
);

@@ sim/window_mean_checker.sv @@
// Checker that predicts and compares the window mean response beats.
module window_mean_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [mwa_pkg::CHAN_W-1:0]   req_channel,
   input  logic [mwa_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [mwa_pkg::CHAN_W-1:0]   rsp_channel_out,
   input  logic [mwa_pkg::MEAN_W-1:0]   rsp_mean,
   input  logic                         rsp_bad_channel,
   output int                           mismatch_count,
   output int                           means_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [mwa_pkg::CHAN_W-1:0] channel;
      logic [mwa_pkg::MEAN_W-1:0] mean;
      logic                       bad;
   } window_result_type;

   // Predicted copy of the per-channel windows, sums and oldest slots.
   logic [63:0]       window_samples [mwa_pkg::CHANNELS][mwa_pkg::WINDOW];
   logic [63:0]       running_sum [mwa_pkg::CHANNELS];
   int                next_slot [mwa_pkg::CHANNELS];
   window_result_type expected_means [$];

   // Replace the oldest sample of a channel and return the new mean.
   function automatic window_result_type advance_window(
      input logic [mwa_pkg::CHAN_W-1:0]   ch,
      input logic [mwa_pkg::SAMPLE_W-1:0] smp);
      window_result_type res;
      logic [63:0]       kept;
      int                slot;
      res.channel = ch;
      res.mean    = '0;
      res.bad     = 1'b0;
      if (ch >= mwa_pkg::CHANNELS) begin
         // An invalid channel leaves every window untouched.
         res.bad = 1'b1;
         return res;
      end
      kept = 64'(smp) & ((64'd1 << mwa_pkg::SAMPLE_BITS) - 64'd1);
      slot = next_slot[ch];
      if (slot >= mwa_pkg::WINDOW) slot = 0;
      running_sum[ch] = running_sum[ch] - window_samples[ch][slot] + kept;
      window_samples[ch][slot] = kept;
      slot = slot + 1;
      if (slot >= mwa_pkg::WINDOW) slot = 0;
      next_slot[ch] = slot;
      res.mean = mwa_pkg::MEAN_W'(running_sum[ch] / 64'(mwa_pkg::WINDOW));
      return res;
   endfunction

   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         for (int c = 0; c < mwa_pkg::CHANNELS; c++) begin
            running_sum[c] = '0;
            next_slot[c]   = 0;
            for (int s = 0; s < mwa_pkg::WINDOW; s++) window_samples[c][s] = '0;
         end
         expected_means.delete();
         mismatch_count = 0;
      end else begin
         // Compare each response beat against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (expected_means.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected response beat: channel %0d mean %0d bad %0b",
                           $realtime, rsp_channel_out, rsp_mean, rsp_bad_channel);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_means.pop_front();
               if (rsp_channel_out !== want.channel || rsp_mean !== want.mean ||
                   rsp_bad_channel !== want.bad) begin
                  if (mismatch_count < 10)
                     $display("%0t: mismatch: channel %0d/%0d mean %0d/%0d bad %0b/%0b %s",
                              $realtime, want.channel, rsp_channel_out, want.mean,
                              rsp_mean, want.bad, rsp_bad_channel, "(expected/actual)");
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         // Each request beat yields exactly one predicted response.
         if (req_valid && req_ready)
            expected_means.push_back(advance_window(req_channel, req_sample));
      end
      means_pending = expected_means.size();
   end

endmodule

@@ sim/multichannel_window_average_top_tb.sv @@
// Testbench top: stimulus, flow control and verdict for the window average block.
module multichannel_window_average_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 1130;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 5000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [mwa_pkg::CHAN_W-1:0]   req_channel = '0;
   logic [mwa_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [mwa_pkg::CHAN_W-1:0]   rsp_channel_out;
   logic [mwa_pkg::MEAN_W-1:0]   rsp_mean;
   logic                         rsp_bad_channel;
   int                           mismatch_count;
   int                           means_pending;
   bit                           hold_request = 1'b0;
   int                           quiet_cycles = 0;

   always #5 clock = ~clock;

   multichannel_window_average_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel_out (rsp_channel_out),
      .rsp_mean        (rsp_mean),
      .rsp_bad_channel (rsp_bad_channel)
   );

   window_mean_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel_out (rsp_channel_out),
      .rsp_mean        (rsp_mean),
      .rsp_bad_channel (rsp_bad_channel),
      .mismatch_count  (mismatch_count),
      .means_pending   (means_pending)
   );

   // Offer one sample beat and hold it until the block takes it.
   task automatic send_sample(input logic [mwa_pkg::CHAN_W-1:0]   ch,
                              input logic [mwa_pkg::SAMPLE_W-1:0] smp);
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= smp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stimulus: directed corner beats, then bursts of random beats.
   initial begin
      int                           burst_left;
      int                           gap;
      int                           hot_left;
      logic [mwa_pkg::CHAN_W-1:0]   hot_channel;
      logic [mwa_pkg::CHAN_W-1:0]   ch;
      logic [mwa_pkg::SAMPLE_W-1:0] smp;
      burst_left  = 0;
      hot_left    = 0;
      hot_channel = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Fill one window with full-scale samples and wrap around it.
      for (int k = 0; k < 13; k++) send_sample(4'd0, 16'hFFFF);
      send_sample(4'd11, 16'h0001);
      send_sample(4'd12, 16'hABCD);
      send_sample(4'd15, 16'hFFFF);
      req_valid <= 1'b0;
      repeat (3) @(posedge clock);
      send_sample(4'd5, 16'h8000);
      send_sample(4'd0, 16'h0000);
      send_sample(4'd0, 16'h0000);
      send_sample(4'd10, 16'h5555);
      send_sample(4'd7, 16'hAAAA);
      send_sample(4'd13, 16'h0000);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 40);
         end
         if (i == HOLD_AT) begin
            // Keep offering beats while the response side holds off.
            hold_request = 1'b1;
            burst_left   = 400;
         end

         // Runs on one channel exercise back-to-back updates of the same window.
         if (hot_left == 0 && $urandom_range(0, 9) == 0) begin
            hot_left    = $urandom_range(2, 20);
            hot_channel = mwa_pkg::CHAN_W'($urandom_range(0, mwa_pkg::CHANNELS - 1));
         end
         if (hot_left > 0) begin
            ch       = hot_channel;
            hot_left = hot_left - 1;
         end else if ($urandom_range(0, 9) == 0) begin
            ch = mwa_pkg::CHAN_W'($urandom_range(mwa_pkg::CHANNELS, 15));
         end else begin
            ch = mwa_pkg::CHAN_W'($urandom_range(0, mwa_pkg::CHANNELS - 1));
         end
         case ($urandom_range(0, 7))
            0:       smp = '0;
            1:       smp = '1;
            2:       smp = mwa_pkg::SAMPLE_W'($urandom_range(0, 15));
            3:       smp = mwa_pkg::SAMPLE_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: smp = mwa_pkg::SAMPLE_W'($urandom);
         endcase
         send_sample(ch, smp);
         burst_left = burst_left - 1;
      end
      req_valid <= 1'b0;

      // Let the checker record the last request beat, drain the remaining
      // responses, then allow for the pipeline depth.
      @(posedge clock);
      while (means_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && means_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Response side: segments of steady, random, patterned and withheld readiness.
   initial begin
      int  seg_left;
      int  seg_mode;
      int  phase;
      bit  hold_done;
      seg_left  = 0;
      seg_mode  = 0;
      phase     = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            // One long hold-off so the block backs up into its input.
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 3);
               seg_left = (seg_mode == 3) ? $urandom_range(1, 8) : $urandom_range(8, 60);
            end
            case (seg_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 9) < 7);
               2:       rsp_ready <= (phase % 3 != 0);
               default: rsp_ready <= 1'b0;
            endcase
            seg_left = seg_left - 1;
            phase    = phase + 1;
         end
      end
   end

   // Watchdog: end the run if no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
